FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define LBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;
  localparam int MAX_ENTRIES = 4096;
  localparam int BLOCK_WORDS = 32;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int WIDX_W      = $clog2(BLOCK_WORDS);
  localparam int WCNT_W      = $clog2(BLOCK_WORDS + 1);
  localparam int DATA_AW     = SLOT_W + WIDX_W;
  localparam int DATA_DEPTH  = MAX_ENTRIES * BLOCK_WORDS;
  localparam int ENT_W       = 13;
  localparam int TAG_W       = 12;
  localparam int STAMP_W     = 32;
  localparam int CNT_W       = 32;
  localparam int WORD_W      = 64;
  localparam int MIN_ENTRIES = 2;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic              inv_found;
    logic [SLOT_W-1:0] inv_slot;
    logic [SLOT_W-1:0] best_slot;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ACT,
    ST_WORD,
    ST_RESP,
    ST_RD,
    ST_LOAD
  } state_t;
endpackage

FILE: rtl/lbc_req_if.sv
`timescale 1ns / 1ps
interface lbc_req_if;
  import lbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [3:0]        disk;
  logic [7:0]        block_index;
  logic [WORD_W-1:0] word_in;
  logic              last_word;
  modport source (output valid, opcode, disk, block_index, word_in, last_word, input ready);
  modport sink (input valid, opcode, disk, block_index, word_in, last_word, output ready);
endinterface

FILE: rtl/lbc_rsp_if.sv
`timescale 1ns / 1ps
interface lbc_rsp_if;
  import lbc_pkg::*;
  logic              valid;
  logic              ready;
  logic              status;
  logic [WORD_W-1:0] word_out;
  logic              last_result;
  logic [CNT_W-1:0]  query_count;
  logic [CNT_W-1:0]  hit_count;
  modport source (output valid, status, word_out, last_result, query_count, hit_count,
                  input ready);
  modport sink (input valid, status, word_out, last_result, query_count, hit_count,
                output ready);
endinterface

FILE: rtl/lbc_cfg_if.sv
`timescale 1ns / 1ps
interface lbc_cfg_if;
  import lbc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ENT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/lbc_ram.sv
`timescale 1ns / 1ps
module lbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/lbc_scan.sv
`timescale 1ns / 1ps
module lbc_scan (
  input  logic                      clk,
  input  logic                      start,
  input  logic                      rd_vld,
  input  logic [lbc_pkg::SLOT_W-1:0] rd_idx,
  input  lbc_pkg::meta_t            rd_meta,
  input  logic [lbc_pkg::TAG_W-1:0] key,
  output lbc_pkg::scan_res_t        res
);
  import lbc_pkg::*;

  logic               first;
  logic [STAMP_W-1:0] best_stamp;

  always_ff @(posedge clk) begin
    if (start) begin
      res.found     <= 1'b0;
      res.inv_found <= 1'b0;
      first         <= 1'b1;
    end else if (rd_vld) begin
      if (rd_meta.valid && rd_meta.tag == key && !res.found) begin
        res.found    <= 1'b1;
        res.hit_slot <= rd_idx;
      end
      if (!rd_meta.valid && !res.inv_found) begin
        res.inv_found <= 1'b1;
        res.inv_slot  <= rd_idx;
      end
      // strict compare keeps the lowest index on equal stamps
      if (first || rd_meta.stamp < best_stamp) begin
        res.best_slot <= rd_idx;
        best_stamp    <= rd_meta.stamp;
      end
      first <= 1'b0;
    end
  end
endmodule

FILE: rtl/lru_block_cache.sv
`timescale 1ns / 1ps
// lru_block_cache: fully associative cache of 64-bit x 32-word blocks keyed by
// disk and block number, least recently used replacement.
// channels: req (sink) carries lookup, insert and update items; rsp (source)
// returns results; cfg (sink) writes entries_in_use, always ready.
// a lookup, or the first item of an insert or update run, scans the tag and
// stamp memory one entry a cycle over the usable entries (entries_in_use, at
// most 4096). a lookup hit then reads the data memory word by word, each word
// loaded once the output register is free, giving 32 result beats.
// later words of a run skip the scan; the last word gives one result beat.
// with the cache disabled no scan is made.
// after reset, and after each cfg write, a clearing pass walks all 4096 entries
// of the tag and stamp memory; req.ready stays low until it ends.
// results sit in an output register; new items are taken while one waits, but
// the block holds its next result until rsp.ready takes the waiting beat.
module lru_block_cache (
  input  logic       clk,
  input  logic       rst,
  lbc_req_if.sink    req,
  lbc_rsp_if.source  rsp,
  lbc_cfg_if.sink    cfg
);
  import lbc_pkg::*;

  state_t state, state_next;

  logic [SLOT_W:0]    sweep;
  logic               sweeping;
  logic [ENT_W-1:0]   entries;
  logic [ENT_W-1:0]   n_use;
  logic               cache_on;
  logic [CNT_W-1:0]   time_cnt, queries, hits;
  logic [SLOT_W-1:0]  target_slot;
  logic [WCNT_W-1:0]  widx;
  logic               op_failed, run_active, resp_status;
  logic [1:0]         op;
  logic [TAG_W-1:0]   key;
  logic [WORD_W-1:0]  word;
  logic               last;
  logic [ENT_W-1:0]   scan_idx;
  logic               rd_vld;
  logic [SLOT_W-1:0]  rd_idx;
  logic [WIDX_W-1:0]  k;
  logic               out_free;

  logic               meta_we;
  logic [SLOT_W-1:0]  meta_waddr;
  meta_t              meta_wdata, meta_rdata;
  logic               meta_re;
  logic               data_we, data_re;
  logic [DATA_AW-1:0] data_waddr, data_raddr;
  logic [WORD_W-1:0]  data_rdata;
  scan_res_t          sres;

  logic accept, cfg_wr, scan_start, load_out;

  assign sweeping = !sweep[SLOT_W];
  assign n_use    = (entries > ENT_W'(MAX_ENTRIES)) ? ENT_W'(MAX_ENTRIES) : entries;
  assign cache_on = entries >= ENT_W'(MIN_ENTRIES);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && !sweeping;
  assign cfg.ready = 1'b1;
  assign accept    = req.valid && req.ready;
  assign cfg_wr    = cfg.valid && cfg.ready;

  lbc_ram #(.WIDTH(META_W), .DEPTH(MAX_ENTRIES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .re(meta_re), .raddr(scan_idx[SLOT_W-1:0]), .rdata(meta_rdata)
  );

  lbc_ram #(.WIDTH(WORD_W), .DEPTH(DATA_DEPTH)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(word),
    .re(data_re), .raddr(data_raddr), .rdata(data_rdata)
  );

  lbc_scan u_scan (
    .clk(clk), .start(scan_start), .rd_vld(rd_vld), .rd_idx(rd_idx),
    .rd_meta(meta_rdata), .key(key), .res(sres)
  );

  assign meta_re    = (state == ST_SCAN);
  assign scan_start = accept;
  assign data_raddr = {sres.hit_slot, k};
  assign data_re    = (state == ST_RD);
  assign data_waddr = {target_slot, widx[WIDX_W-1:0]};
  assign data_we    = (state == ST_WORD) && !op_failed && (widx < WCNT_W'(BLOCK_WORDS));

  always_comb begin
    state_next = state;
    meta_we    = 1'b0;
    meta_waddr = sres.hit_slot;
    meta_wdata = '{valid: 1'b1, tag: key, stamp: time_cnt + 1'b1};
    load_out   = 1'b0;
    if (sweeping) begin
      meta_we    = 1'b1;
      meta_waddr = sweep[SLOT_W-1:0];
      meta_wdata = '0;
    end
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.opcode)
            OP_LOOKUP: state_next = cache_on ? ST_SCAN : ST_RESP;
            OP_INSERT, OP_UPDATE:
              state_next = (run_active || !cache_on) ? ST_WORD : ST_SCAN;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx == n_use - 1'b1) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_ACT;
      ST_ACT: begin
        case (op)
          OP_LOOKUP: begin
            meta_we    = sres.found;
            state_next = sres.found ? ST_RD : ST_RESP;
          end
          OP_INSERT: begin
            meta_we    = !sres.found;
            meta_waddr = sres.inv_found ? sres.inv_slot : sres.best_slot;
            state_next = ST_WORD;
          end
          default: begin
            meta_we          = sres.found;
            meta_wdata.stamp = time_cnt;
            state_next       = ST_WORD;
          end
        endcase
      end
      ST_WORD: state_next = last ? ST_RESP : ST_IDLE;
      ST_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RD: state_next = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = (k == WIDX_W'(BLOCK_WORDS - 1)) ? ST_IDLE : ST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (cfg_wr) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= meta_re;
    rd_idx <= scan_idx[SLOT_W-1:0];
    if (accept) begin
      op   <= req.opcode;
      key  <= {req.disk, req.block_index};
      word <= req.word_in;
      last <= req.last_word;
    end
    if (accept) begin
      scan_idx <= '0;
      k        <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end else if (state == ST_LOAD && out_free) begin
      k <= k + 1'b1;
    end
    if (load_out) begin
      rsp.status      <= (state == ST_RESP) ? resp_status : 1'b0;
      rsp.word_out    <= (state == ST_RESP) ? '0 : data_rdata;
      rsp.last_result <= (state == ST_RESP) || (k == WIDX_W'(BLOCK_WORDS - 1));
      rsp.query_count <= queries;
      rsp.hit_count   <= hits;
    end
    if (state == ST_ACT && op == OP_INSERT) begin
      target_slot <= sres.inv_found ? sres.inv_slot : sres.best_slot;
    end else if (state == ST_ACT && op == OP_UPDATE) begin
      target_slot <= sres.hit_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep       <= '0;
      entries     <= '0;
      time_cnt    <= '0;
      queries     <= '0;
      hits        <= '0;
      widx        <= '0;
      op_failed   <= 1'b0;
      run_active  <= 1'b0;
      resp_status <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (sweeping) sweep <= sweep + 1'b1;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (cfg_wr) begin
        entries    <= cfg.data;
        sweep      <= '0;
        run_active <= 1'b0;
        widx       <= '0;
        op_failed  <= 1'b0;
      end else begin
        if (accept) begin
          case (req.opcode)
            OP_LOOKUP: begin
              run_active  <= 1'b0;
              widx        <= '0;
              queries     <= queries + 1'b1;
              resp_status <= 1'b1;
            end
            OP_INSERT, OP_UPDATE: begin
              if (!run_active) begin
                run_active <= 1'b1;
                widx       <= '0;
                op_failed  <= !cache_on;
              end
            end
            default: ;
          endcase
        end
        if (state == ST_ACT) begin
          case (op)
            OP_LOOKUP: begin
              if (sres.found) begin
                time_cnt <= time_cnt + 1'b1;
                hits     <= hits + 1'b1;
              end
            end
            OP_INSERT: begin
              if (sres.found) begin
                op_failed <= 1'b1;
              end else begin
                time_cnt <= time_cnt + 1'b1;
              end
            end
            default: op_failed <= !sres.found;
          endcase
        end
        if (state == ST_WORD) begin
          if (last) begin
            resp_status <= op_failed;
            run_active  <= 1'b0;
            widx        <= '0;
            op_failed   <= 1'b0;
          end else if (widx < WCNT_W'(BLOCK_WORDS)) begin
            widx <= widx + 1'b1;
          end
        end
      end
    end
  end

`include "assert_macros.svh"

  `LBC_ASSERT(a_no_accept_in_sweep, sweeping |-> !req.ready, "item taken during clearing pass")
  `LBC_ASSERT(a_data_write_in_run, data_we |-> run_active && !op_failed, "data write outside a good run")
  `LBC_ASSERT(a_cfg_restarts_sweep, cfg_wr |=> sweeping && !run_active, "config write did not clear")
  `LBC_ASSERT_ALWAYS(a_reset_state, rst |=> sweeping && !rsp.valid, "reset left output or memory live")
endmodule
